### design/lpfp_pkg.sv
// Shared types and constants of the length-prefixed frame parser.
`timescale 1ns / 1ps

package lpfp_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned SIG_BYTES    = 64;
  localparam int unsigned KEY_BYTES    = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_CODE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MESSAGE_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_PUBLISH_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_ENABLE          = 3'd4;

  // Input commands
  localparam logic CMD_DATA      = 1'b0;
  localparam logic CMD_LINK_DROP = 1'b1;

  // Region tags
  localparam logic [2:0] REGION_HEADER    = 3'd0;
  localparam logic [2:0] REGION_TOPIC     = 3'd1;
  localparam logic [2:0] REGION_PAYLOAD   = 3'd2;
  localparam logic [2:0] REGION_SIGNATURE = 3'd3;
  localparam logic [2:0] REGION_KEY_ID    = 3'd4;
  localparam logic [2:0] REGION_NONE      = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_BAD_VERSION = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW    = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  region;
    logic        frame_done;
    logic [1:0]  error_code;
    logic [7:0]  command_code;
    logic [63:0] sequence_number;
    logic [31:0] key_id;
    logic [15:0] topic_length;
    logic [31:0] payload_length;
    logic        signed_frame;
    logic        deliver_message;
    logic        ack_needed;
  } out_word_t;

  typedef struct packed {
    logic [7:0] protocol_version;
    logic [7:0] message_code;
    logic [7:0] signed_message_code;
    logic [7:0] signed_publish_code;
    logic       ack_enable;
  } cfg_t;

endpackage

### design/lpfp_core.sv
// Frame parse state and per-word result logic.
`timescale 1ns / 1ps

module lpfp_core #(
  parameter int unsigned BUFFER_BYTES = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  lpfp_pkg::in_word_t   in_word,
  input  lpfp_pkg::cfg_t       cfg,
  output lpfp_pkg::out_word_t  result
);
  import lpfp_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_HDR      = CNT_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_HDR_LAST = CNT_W'(HEADER_BYTES - 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       version_r, version_nxt;
  logic [7:0]       command_r, command_nxt;
  logic [63:0]      sequence_r, sequence_nxt;
  logic [15:0]      topic_len_r, topic_len_nxt;
  logic [31:0]      payload_len_r, payload_len_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [32:0]      total_r, total_nxt;
  // region boundaries, captured with the header
  logic [16:0]      topic_end_r, topic_end_nxt;
  logic [32:0]      payload_end_r, payload_end_nxt;
  logic [33:0]      sig_end_r, sig_end_nxt;

  logic [CNT_W-1:0] idx;
  logic             overflow;
  logic             hdr_last;
  logic             bad_version;
  logic             hdr_signed;
  logic [32:0]      body_end;
  logic [2:0]       region;
  logic             done;
  logic             sgn;
  logic             dlv;

  always_comb begin
    count_nxt       = count_r;
    version_nxt     = version_r;
    command_nxt     = command_r;
    sequence_nxt    = sequence_r;
    topic_len_nxt   = topic_len_r;
    payload_len_nxt = payload_len_r;
    key_nxt         = key_r;
    total_nxt       = total_r;
    topic_end_nxt   = topic_end_r;
    payload_end_nxt = payload_end_r;
    sig_end_nxt     = sig_end_r;
    result          = '0;

    overflow    = (count_r >= CNT_FULL);
    idx         = overflow ? '0 : count_r;
    hdr_last    = (idx == CNT_HDR_LAST);
    bad_version = 1'b0;
    region      = REGION_HEADER;
    done        = 1'b0;

    if (idx == '0) begin
      version_nxt = in_word.rx_byte;
      key_nxt     = '0;
    end else if (idx == CNT_W'(1)) begin
      command_nxt = in_word.rx_byte;
    end else if (idx < CNT_W'(10)) begin
      sequence_nxt = {sequence_r[55:0], in_word.rx_byte};
    end else if (idx < CNT_W'(12)) begin
      topic_len_nxt = {topic_len_r[7:0], in_word.rx_byte};
    end else if (idx < CNT_HDR) begin
      payload_len_nxt = {payload_len_r[23:0], in_word.rx_byte};
    end

    hdr_signed = (command_r == cfg.signed_publish_code) ||
                 (command_r == cfg.signed_message_code);
    body_end   = 33'(HEADER_BYTES) + 33'(topic_len_r) + 33'(payload_len_nxt);

    if (idx >= CNT_HDR) begin
      if (34'(idx) < 34'(topic_end_r))        region = REGION_TOPIC;
      else if (34'(idx) < 34'(payload_end_r)) region = REGION_PAYLOAD;
      else if (34'(idx) < sig_end_r)          region = REGION_SIGNATURE;
      else                                    region = REGION_KEY_ID;
      if (region == REGION_KEY_ID) key_nxt = {key_r[23:0], in_word.rx_byte};
    end

    count_nxt = idx + CNT_W'(1);
    if (hdr_last) begin
      if (version_r != cfg.protocol_version) begin
        bad_version = 1'b1;
        count_nxt   = '0;
      end else begin
        topic_end_nxt   = 17'(HEADER_BYTES) + 17'(topic_len_r);
        payload_end_nxt = body_end;
        sig_end_nxt     = 34'(body_end) + 34'(SIG_BYTES);
        total_nxt       = body_end + (hdr_signed ? 33'(SIG_BYTES + KEY_BYTES) : 33'd0);
      end
    end

    sgn = (command_nxt == cfg.signed_publish_code) ||
          (command_nxt == cfg.signed_message_code);
    dlv = (command_nxt == cfg.message_code) ||
          (command_nxt == cfg.signed_message_code);

    if ((count_nxt >= CNT_HDR) && (33'(count_nxt) == total_nxt)) begin
      done                   = 1'b1;
      count_nxt              = '0;
      result.command_code    = command_nxt;
      result.sequence_number = sequence_nxt;
      result.key_id          = sgn ? key_nxt : 32'd0;
      result.topic_length    = topic_len_nxt;
      result.payload_length  = payload_len_nxt;
      result.signed_frame    = sgn;
      result.deliver_message = dlv;
      result.ack_needed      = dlv && cfg.ack_enable && (sequence_nxt != 64'd0);
    end

    result.byte_value = in_word.rx_byte;
    result.region     = region;
    result.frame_done = done;
    result.error_code = bad_version ? ERR_BAD_VERSION :
                        overflow    ? ERR_OVERFLOW    : ERR_NONE;

    if (in_word.cmd == CMD_LINK_DROP) begin
      // link drop: only the count moves, the word reports nothing
      count_nxt       = '0;
      version_nxt     = version_r;
      command_nxt     = command_r;
      sequence_nxt    = sequence_r;
      topic_len_nxt   = topic_len_r;
      payload_len_nxt = payload_len_r;
      key_nxt         = key_r;
      total_nxt       = total_r;
      topic_end_nxt   = topic_end_r;
      payload_end_nxt = payload_end_r;
      sig_end_nxt     = sig_end_r;
      result          = '0;
      result.region   = REGION_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      version_r     <= '0;
      command_r     <= '0;
      sequence_r    <= '0;
      topic_len_r   <= '0;
      payload_len_r <= '0;
      key_r         <= '0;
      total_r       <= '0;
      topic_end_r   <= '0;
      payload_end_r <= '0;
      sig_end_r     <= '0;
    end else if (accept) begin
      count_r       <= count_nxt;
      version_r     <= version_nxt;
      command_r     <= command_nxt;
      sequence_r    <= sequence_nxt;
      topic_len_r   <= topic_len_nxt;
      payload_len_r <= payload_len_nxt;
      key_r         <= key_nxt;
      total_r       <= total_nxt;
      topic_end_r   <= topic_end_nxt;
      payload_end_r <= payload_end_nxt;
      sig_end_r     <= sig_end_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("byte count beyond buffer size");

  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_word.cmd == CMD_LINK_DROP) |=> count_r == '0)
    else $error("link drop did not clear the parse");

  a_bad_version_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_word.cmd == CMD_DATA) && bad_version |=> count_r == '0)
    else $error("bad version frame not dropped");
`endif

endmodule

### design/length_prefixed_frame_parser.sv
// Length-prefixed frame parser: top level with config registers and output buffer.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (in_valid / in_stall / in_data): one word per accept, either a
//    received byte or a link-drop event that clears the parse.
//  - Output channel (out_valid / out_stall / out_data): exactly one result word
//    for every input word, in order: byte echo, region tag, error code, and on
//    the last byte of a frame the header fields, key id and delivery/ACK flags.
//  - Config port (cfg_we / cfg_index / cfg_data): write-only registers that the
//    user must write only while no word is in flight; the block has no check.
//  - Results: registered in out_r on accept, or in skid_r while the output is stalled.
//  - Throughput: one word per cycle while in_stall is low; a byte only updates
//    counters and shift registers between input handshake and output register.
//  - Stall: a two-entry output buffer (output register plus skid register)
//    absorbs one word of stall; in_stall rises only when the skid entry is
//    occupied, so in_stall is a pure register output.
//  - Reset (rst_n low, synchronous): parse state cleared, config registers
//    return to version 1, all command codes 0, ACK enabled; output empty.
module length_prefixed_frame_parser #(
  parameter int unsigned BUFFER_BYTES = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lpfp_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lpfp_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [lpfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpfp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lpfp_pkg::*;

  cfg_t      cfg_r;
  out_word_t result;
  out_word_t out_r;
  out_word_t skid_r;
  logic      out_v_r;
  logic      skid_v_r;
  logic      accept;

  assign in_stall  = skid_v_r;
  assign accept    = in_valid && !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protocol_version    <= 8'd1;
      cfg_r.message_code        <= 8'd0;
      cfg_r.signed_message_code <= 8'd0;
      cfg_r.signed_publish_code <= 8'd0;
      cfg_r.ack_enable          <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROTOCOL_VERSION:    cfg_r.protocol_version    <= cfg_data;
        CFG_MESSAGE_CODE:        cfg_r.message_code        <= cfg_data;
        CFG_SIGNED_MESSAGE_CODE: cfg_r.signed_message_code <= cfg_data;
        CFG_SIGNED_PUBLISH_CODE: cfg_r.signed_publish_code <= cfg_data;
        CFG_ACK_ENABLE:          cfg_r.ack_enable          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lpfp_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_word(in_data),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && out_stall) begin
      // output held: park a new word in the skid entry
      if (accept) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && out_stall) begin
      if (accept) skid_r <= result;
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else if (accept) begin
      out_r <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry occupied with empty output register");

  a_done_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.frame_done |-> out_r.error_code != ERR_BAD_VERSION)
    else $error("frame completed on a bad version");

  a_unsigned_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.signed_frame |-> out_r.key_id == 32'd0)
    else $error("key id reported for an unsigned frame");
`endif

endmodule
